[rtl/cpg_pkg.sv]
`timescale 1ns / 1ps

package cpg_pkg;

    // operation codes of an input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam int COORD_W = 8;
    localparam int DEC_W   = 12;

    // step queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int PT_IDX_W = 3;
    localparam logic [PT_IDX_W-1:0] PT_LAST = 3'd7;

    // one step of the walk: the eight points derive from this
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        logic               done;
    } t_step_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/circle_point_generator.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in       sink       i_in_valid / o_in_stall    i_operation, i_center_x, i_center_y, i_radius
// out      source     o_out_valid / i_out_stall  o_point_x, o_point_y, o_on_screen,
//                                                o_last_of_step, o_circle_done
//
// A start item is taken and gives no point. A step item is taken and, while a circle is
// running, queued; the point stage then gives its eight points at one point per cycle
// while the output is not stalled, through the single output register.
// The step queue holds four steps; the input stalls only while it is full.
// Reset is synchronous and active low; it clears the walk, the queue and the output valid.
// An output stall holds the current point and, once the queue fills, the input.

module circle_point_generator #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [cpg_pkg::COORD_W-1:0] i_center_x,
    input  logic [cpg_pkg::COORD_W-1:0] i_center_y,
    input  logic [cpg_pkg::COORD_W-1:0] i_radius,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [cpg_pkg::COORD_W-1:0] o_point_x,
    output logic [cpg_pkg::COORD_W-1:0] o_point_y,
    output logic                        o_on_screen,
    output logic                        o_last_of_step,
    output logic                        o_circle_done
);

    logic               push;
    logic               pop;
    cpg_pkg::t_step_rec push_rec;
    cpg_pkg::t_step_rec head;
    cpg_pkg::t_q_status q_status;

    cpg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_operation(i_operation),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_rec (push_rec)
    );

    cpg_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_rec(push_rec),
        .i_pop     (pop),
        .o_head    (head),
        .o_status  (q_status)
    );

    cpg_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_on_screen   (o_on_screen),
        .o_last_of_step(o_last_of_step),
        .o_circle_done (o_circle_done)
    );

endmodule

[rtl/cpg_front.sv]
`timescale 1ns / 1ps

module cpg_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [cpg_pkg::COORD_W-1:0] i_center_x,
    input  logic [cpg_pkg::COORD_W-1:0] i_center_y,
    input  logic [cpg_pkg::COORD_W-1:0] i_radius,
    input  cpg_pkg::t_q_status          i_q_status,
    output logic                        o_push,
    output cpg_pkg::t_step_rec          o_push_rec
);

    logic [cpg_pkg::COORD_W-1:0] r_cx, n_cx;
    logic [cpg_pkg::COORD_W-1:0] r_cy, n_cy;
    logic [cpg_pkg::COORD_W-1:0] r_a, n_a;
    logic [cpg_pkg::COORD_W-1:0] r_b, n_b;
    logic [cpg_pkg::DEC_W-1:0]   r_dec, n_dec;
    logic                        r_busy, n_busy;

    logic                        accept;
    logic [cpg_pkg::COORD_W:0]   na;
    logic [cpg_pkg::COORD_W:0]   na_plus1;
    logic [cpg_pkg::COORD_W:0]   b_ext;
    logic                        dec_neg;
    logic                        step_done;
    logic [cpg_pkg::DEC_W-1:0]   dec_inc_neg;
    logic [cpg_pkg::DEC_W-1:0]   dec_inc_pos;
    logic [cpg_pkg::DEC_W-1:0]   ab_diff;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;

    assign na       = {1'b0, r_a} + 9'd1;
    assign na_plus1 = {1'b0, r_a} + 9'd2;
    assign b_ext    = {1'b0, r_b};
    assign dec_neg  = r_dec[cpg_pkg::DEC_W-1];

    // end test on full values: b may step below zero
    assign step_done = dec_neg ? (na > b_ext) : (na_plus1 > b_ext);

    assign ab_diff     = {3'b000, na} - {4'b0000, r_b};
    assign dec_inc_neg = {1'b0, na, 2'b00} + 12'd6;
    assign dec_inc_pos = {ab_diff[cpg_pkg::DEC_W-3:0], 2'b00} + 12'd10;

    assign o_push          = accept && (i_operation == cpg_pkg::OP_STEP) && r_busy;
    assign o_push_rec.cx   = r_cx;
    assign o_push_rec.cy   = r_cy;
    assign o_push_rec.a    = r_a;
    assign o_push_rec.b    = r_b;
    assign o_push_rec.done = step_done;

    always_comb begin
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_a    = r_a;
        n_b    = r_b;
        n_dec  = r_dec;
        n_busy = r_busy;
        if (accept && (i_operation == cpg_pkg::OP_START)) begin
            n_cx   = i_center_x;
            n_cy   = i_center_y;
            n_a    = '0;
            n_b    = i_radius;
            n_dec  = 12'd3 - {3'b000, i_radius, 1'b0};
            n_busy = 1'b1;
        end else if (o_push) begin
            n_a    = na[cpg_pkg::COORD_W-1:0];
            n_b    = dec_neg ? r_b : (r_b - 8'd1);
            n_dec  = r_dec + (dec_neg ? dec_inc_neg : dec_inc_pos);
            n_busy = !step_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_a    <= '0;
            r_b    <= '0;
            r_dec  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_a    <= n_a;
            r_b    <= n_b;
            r_dec  <= n_dec;
            r_busy <= n_busy;
        end
    end

endmodule

[rtl/cpg_queue.sv]
`timescale 1ns / 1ps

module cpg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cpg_pkg::t_step_rec i_push_rec,
    input  logic               i_pop,
    output cpg_pkg::t_step_rec o_head,
    output cpg_pkg::t_q_status o_status
);

    cpg_pkg::t_step_rec r_mem [cpg_pkg::Q_DEPTH];

    logic [cpg_pkg::Q_PTR_W-1:0] r_wr, n_wr;
    logic [cpg_pkg::Q_PTR_W-1:0] r_rd, n_rd;
    logic [cpg_pkg::Q_CNT_W-1:0] r_count, n_count;

    assign o_status.full  = (r_count == cpg_pkg::Q_CNT_W'(cpg_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("step queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("step queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cpg_pkg::Q_CNT_W'(cpg_pkg::Q_DEPTH))
        else $error("step queue count beyond depth");
`endif

endmodule

[rtl/cpg_back.sv]
`timescale 1ns / 1ps

module cpg_back #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cpg_pkg::t_step_rec          i_head,
    input  cpg_pkg::t_q_status          i_q_status,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [cpg_pkg::COORD_W-1:0] o_point_x,
    output logic [cpg_pkg::COORD_W-1:0] o_point_y,
    output logic                        o_on_screen,
    output logic                        o_last_of_step,
    output logic                        o_circle_done
);

    logic [cpg_pkg::PT_IDX_W-1:0] r_idx, n_idx;
    logic                         r_valid, n_valid;
    logic [cpg_pkg::COORD_W-1:0]  r_x, r_y;
    logic                         r_on, r_last, r_done;

    logic                         load;
    logic                         is_last;
    logic [cpg_pkg::COORD_W-1:0]  px, py;
    logic [cpg_pkg::COORD_W-1:0]  cxpa, cxma, cxpb, cxmb;
    logic [cpg_pkg::COORD_W-1:0]  cypa, cyma, cypb, cymb;

    assign load    = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign is_last = (r_idx == cpg_pkg::PT_LAST);
    assign o_pop   = load && is_last;

    assign cxpa = i_head.cx + i_head.a;
    assign cxma = i_head.cx - i_head.a;
    assign cxpb = i_head.cx + i_head.b;
    assign cxmb = i_head.cx - i_head.b;
    assign cypa = i_head.cy + i_head.a;
    assign cyma = i_head.cy - i_head.a;
    assign cypb = i_head.cy + i_head.b;
    assign cymb = i_head.cy - i_head.b;

    // octant order of one step
    always_comb begin
        case (r_idx)
            3'd0:    begin px = cxpa; py = cymb; end
            3'd1:    begin px = cxpb; py = cyma; end
            3'd2:    begin px = cxpb; py = cypa; end
            3'd3:    begin px = cxpa; py = cypb; end
            3'd4:    begin px = cxma; py = cypb; end
            3'd5:    begin px = cxmb; py = cypa; end
            3'd6:    begin px = cxma; py = cymb; end
            default: begin px = cxmb; py = cyma; end
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = r_idx + 1'b1;
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x    <= px;
            r_y    <= py;
            r_on   <= ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(SCREEN_HEIGHT));
            r_last <= is_last;
            r_done <= is_last && i_head.done;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_point_x      = r_x;
    assign o_point_y      = r_y;
    assign o_on_screen    = r_on;
    assign o_last_of_step = r_last;
    assign o_circle_done  = r_done;

`ifndef SYNTH
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_out_valid && o_last_of_step)
        else $error("step retired without its eighth point");

    a_mid_step_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> !i_q_status.empty)
        else $error("step record lost part way through its points");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_circle_done) |-> o_last_of_step)
        else $error("circle end flagged away from a step end");
`endif

endmodule

[tb/sv/tb_circle_point_generator.sv]
`timescale 1ns / 1ps

module tb_circle_point_generator;

    localparam int SCR_W = 128;
    localparam int SCR_H = 64;

    typedef struct {
        logic                        op;
        logic [cpg_pkg::COORD_W-1:0] cx;
        logic [cpg_pkg::COORD_W-1:0] cy;
        logic [cpg_pkg::COORD_W-1:0] r;
        bit                          drain;
    } t_circle_cmd;

    typedef struct packed {
        logic [cpg_pkg::COORD_W-1:0] px;
        logic [cpg_pkg::COORD_W-1:0] py;
        logic                        on_scr;
        logic                        last;
        logic                        fin;
    } t_circle_point;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        operation = cpg_pkg::OP_START;
    logic [cpg_pkg::COORD_W-1:0] center_x = '0;
    logic [cpg_pkg::COORD_W-1:0] center_y = '0;
    logic [cpg_pkg::COORD_W-1:0] radius = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [cpg_pkg::COORD_W-1:0] point_x;
    logic [cpg_pkg::COORD_W-1:0] point_y;
    logic                        on_screen;
    logic                        last_of_step;
    logic                        circle_done;

    t_circle_cmd   cmd_q[$];
    t_circle_point point_q[$];
    int            mismatches = 0;

    // shadow of the circle walk
    logic [cpg_pkg::COORD_W-1:0]      walk_cx = '0;
    logic [cpg_pkg::COORD_W-1:0]      walk_cy = '0;
    logic [cpg_pkg::COORD_W-1:0]      walk_a = '0;
    logic [cpg_pkg::COORD_W-1:0]      walk_b = '0;
    logic signed [cpg_pkg::DEC_W-1:0] walk_dec = '0;
    bit                               walk_busy = 1'b0;

    circle_point_generator u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (operation),
        .i_center_x     (center_x),
        .i_center_y     (center_y),
        .i_radius       (radius),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_point_x      (point_x),
        .o_point_y      (point_y),
        .o_on_screen    (on_screen),
        .o_last_of_step (last_of_step),
        .o_circle_done  (circle_done)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int idle_len(bit quiet);
        int p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the walk by one item and queue the points it yields.
    function automatic void walk_circle(t_circle_cmd c);
        logic [cpg_pkg::COORD_W-1:0] xs[8];
        logic [cpg_pkg::COORD_W-1:0] ys[8];
        int                          na;
        int                          nb;
        int                          di;
        bit                          fin;
        t_circle_point               pt;
        if (c.op == cpg_pkg::OP_START) begin
            walk_cx   = c.cx;
            walk_cy   = c.cy;
            walk_a    = '0;
            walk_b    = c.r;
            walk_dec  = cpg_pkg::DEC_W'(3 - 2 * int'(c.r));
            walk_busy = 1'b1;
            return;
        end
        if (!walk_busy) return;
        na = int'(walk_a) + 1;
        nb = int'(walk_b);
        di = walk_dec;
        if (di < 0) begin
            di += 4 * na + 6;
        end else begin
            di += 10 + 4 * (na - nb);
            nb -= 1;
        end
        // end test on the full values, before b is narrowed
        fin = na > nb;
        xs = '{walk_cx + walk_a, walk_cx + walk_b, walk_cx + walk_b, walk_cx + walk_a,
               walk_cx - walk_a, walk_cx - walk_b, walk_cx - walk_a, walk_cx - walk_b};
        ys = '{walk_cy - walk_b, walk_cy - walk_a, walk_cy + walk_a, walk_cy + walk_b,
               walk_cy + walk_b, walk_cy + walk_a, walk_cy - walk_b, walk_cy - walk_a};
        for (int k = 0; k < 8; k++) begin
            pt.px     = xs[k];
            pt.py     = ys[k];
            pt.on_scr = (int'(xs[k]) < SCR_W) && (int'(ys[k]) < SCR_H);
            pt.last   = (k == 7);
            pt.fin    = (k == 7) && fin;
            point_q.push_back(pt);
        end
        walk_a    = cpg_pkg::COORD_W'(na);
        walk_b    = cpg_pkg::COORD_W'(nb);
        walk_dec  = cpg_pkg::DEC_W'(di);
        walk_busy = !fin;
    endfunction

    // driver
    int send_gap = 0;
    bit send_quiet = 1'b0;

    always @(posedge clk) begin
        t_circle_cmd c;
        logic        v;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            v = in_valid;
            if (in_valid && !in_stall) begin
                c.op    = operation;
                c.cx    = center_x;
                c.cy    = center_y;
                c.r     = radius;
                c.drain = 1'b0;
                walk_circle(c);
                v = 1'b0;
            end
            if (!v) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cmd_q.size() > 0 &&
                             !(cmd_q[0].drain && point_q.size() > 0)) begin
                    c = cmd_q.pop_front();
                    operation <= c.op;
                    center_x  <= c.cx;
                    center_y  <= c.cy;
                    radius    <= c.r;
                    v = 1'b1;
                    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
                    send_gap = idle_len(send_quiet);
                end
            end
            in_valid <= v;
        end
    end

    // monitor
    int recv_stall = 0;
    bit recv_quiet = 1'b0;

    always @(posedge clk) begin
        t_circle_point want;
        logic          s;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (point_q.size() == 0) begin
                    $error("unexpected point x=%0d y=%0d", point_x, point_y);
                    mismatches++;
                end else begin
                    want = point_q.pop_front();
                    if (point_x !== want.px) begin
                        $error("point_x: expected %0d, got %0d", want.px, point_x);
                        mismatches++;
                    end
                    if (point_y !== want.py) begin
                        $error("point_y: expected %0d, got %0d", want.py, point_y);
                        mismatches++;
                    end
                    if (on_screen !== want.on_scr) begin
                        $error("on_screen: expected %0b, got %0b", want.on_scr, on_screen);
                        mismatches++;
                    end
                    if (last_of_step !== want.last) begin
                        $error("last_of_step: expected %0b, got %0b", want.last, last_of_step);
                        mismatches++;
                    end
                    if (circle_done !== want.fin) begin
                        $error("circle_done: expected %0b, got %0b", want.fin, circle_done);
                        mismatches++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                s = 1'b1;
            end else begin
                s = 1'b0;
                if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
                recv_stall = idle_len(recv_quiet);
            end
            out_stall <= s;
        end
    end

    function automatic void push_cmd(logic op, int cx, int cy, int r, bit drain);
        t_circle_cmd c;
        c.op    = op;
        c.cx    = cpg_pkg::COORD_W'(cx);
        c.cy    = cpg_pkg::COORD_W'(cy);
        c.r     = cpg_pkg::COORD_W'(r);
        c.drain = drain;
        cmd_q.push_back(c);
    endfunction

    function automatic void push_steps(int n);
        for (int k = 0; k < n; k++)
            push_cmd(cpg_pkg::OP_STEP, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), 1'b0);
    endfunction

    initial begin
        int  issued;
        int  sel;
        int  r;
        int  n;
        bit  mid_drain;
        // step with no circle running
        push_steps(1);
        // zero radius: one step of eight centre copies, then idle
        push_cmd(cpg_pkg::OP_START, 0, 0, 0, 1'b0);
        push_steps(2);
        // wrap at the top corner
        push_cmd(cpg_pkg::OP_START, 255, 255, 1, 1'b0);
        push_steps(2);
        // screen edge
        push_cmd(cpg_pkg::OP_START, 127, 63, 2, 1'b0);
        push_steps(3);
        // restart while a circle is running
        push_cmd(cpg_pkg::OP_START, 100, 30, 5, 1'b0);
        push_steps(2);
        push_cmd(cpg_pkg::OP_START, 10, 60, 3, 1'b0);
        push_steps(4);

        issued    = 0;
        mid_drain = 1'b0;
        while (issued < 300) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                // noise
                push_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         issued == 0);
                issued++;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 70)      r = $urandom_range(0, 15);
                else if (sel < 90) r = $urandom_range(16, 63);
                else if (sel < 97) r = $urandom_range(64, 254);
                else               r = 255;
                // full walk bounds a/r at about 0.71, so this covers it with a little spare
                if ($urandom_range(0, 99) < 75) n = r * 3 / 4 + 1 + $urandom_range(0, 1);
                else                            n = $urandom_range(0, r * 3 / 4);
                push_cmd(cpg_pkg::OP_START, $urandom_range(0, 255), $urandom_range(0, 255), r,
                         issued == 0 || (!mid_drain && issued >= 150));
                if (issued >= 150) mid_drain = 1'b1;
                push_steps(n);
                issued += 1 + n;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() > 0 || in_valid || point_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0) begin
            $display("[circle_point_generator] OK");
        end else begin
            $display("[circle_point_generator] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[circle_point_generator] ERROR");
        $finish;
    end

endmodule
